FILE: design/psc_pkg.sv
// Shared types and constants for the pressure sensor conditioner.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package psc_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int SUM_W       = SAMPLE_BITS + 8;
	localparam int CNT_W       = 8;
	localparam int LVL_W       = SUM_W + 8;
	localparam int DEN_W       = SAMPLE_BITS + 8;
	localparam int FS10_W      = 14;
	localparam int DIV_W       = LVL_W + FS10_W;
	localparam int DCNT_W      = $clog2(DIV_W);
	localparam int CFG_W       = 16;
	localparam int CFG_AW      = 3;

	localparam logic [DEN_W-1:0] TOP_LEVEL = DEN_W'(((1 << SAMPLE_BITS) - 1) << 8);
	localparam logic [FS10_W-1:0] FS10_MAX = FS10_W'(1023 * 10);

	typedef enum logic [CFG_AW-1:0] {
		REG_SAMPLES_PER_READING = 3'd0,
		REG_CALIBRATION_SAMPLES = 3'd1,
		REG_SMOOTHING_WEIGHT    = 3'd2,
		REG_DEADBAND_LEVEL      = 3'd3,
		REG_FULL_SCALE_KPA      = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_MEAN_DONE,
		ST_EMA_A,
		ST_EMA_B,
		ST_EMA_C,
		ST_CMP,
		ST_MUL,
		ST_DIV_LOAD,
		ST_DIV_PRESS,
		ST_PRESS_DONE,
		ST_OUT
	} psc_state_t;

	typedef struct packed {
		logic                   req_type;
		logic [SAMPLE_BITS-1:0] raw_sample;
	} sample_t;

	typedef struct packed {
		logic        result_kind;
		logic [13:0] pressure_tenths_kpa;
		logic        in_deadband;
		logic [17:0] zero_level;
	} result_t;

endpackage

FILE: design/pressure_sensor_conditioner_core.sv
// Pressure sensor conditioner: grouping, EMA smoothing, zero and pressure scaling.
// Uses psc_pkg; one shared multiplier and a 40-step restoring divider under a sequencer.
// A sample that does not close a group is taken while idle. A closing calibration sample
// raises result_valid after the mean divide, a closing reading after the compare
// (deadband, below zero, zero span) or pressure divide (scaled), plus any output wait;
// ready rises with it. Reset: arst_n clears control and levels, loads register defaults.
`timescale 1ns / 1ps

module pressure_sensor_conditioner_core
	import psc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result
);

	logic [6:0]        spr_q;
	logic [7:0]        cal_q;
	logic [8:0]        wgt_q;
	logic [15:0]       db_q;
	logic [9:0]        fs_q;

	psc_state_t        state_q, state_n;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              grp_q;
	logic              kind_q;
	logic [LVL_W-1:0]  sm_q;
	logic [LVL_W-1:0]  zero_q;
	logic [LVL_W-1:0]  mean_q;
	logic [LVL_W-1:0]  diff_q;
	logic [DIV_W-1:0]  acc_q;
	logic [DIV_W-1:0]  dnum_q;
	logic [DEN_W-1:0]  drem_q;
	logic [DEN_W-1:0]  dden_q;
	logic [DCNT_W-1:0] dcnt_q;
	result_t           res_q;
	result_t           result_q;
	logic              result_valid_q;

	logic              restart;
	logic [SUM_W-1:0]  sum_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [CNT_W-1:0]  n_raw;
	logic [CNT_W-1:0]  n_eff;
	logic              close_grp;
	logic [8:0]        w_eff;
	logic [8:0]        w_inv;
	logic [FS10_W-1:0] fs10;
	logic [LVL_W-1:0]  mul_a;
	logic [FS10_W-1:0] mul_b;
	logic [DIV_W-1:0]  mul_p;
	logic [DEN_W:0]    trial;
	logic              div_ge;
	logic [DEN_W-1:0]  rem_n;
	logic              lvl_ge;
	logic [LVL_W-1:0]  abs_diff;
	logic              band;
	logic              zero_span;
	logic [DEN_W-1:0]  den;
	logic              load_out;

	// group bookkeeping
	assign restart   = (cnt_q != '0) && (sample.req_type != grp_q);
	assign sum_n     = (restart ? '0 : sum_q) + SUM_W'(sample.raw_sample);
	assign cnt_n     = (restart ? '0 : cnt_q) + 1'b1;
	assign n_raw     = sample.req_type ? cal_q : {1'b0, spr_q};
	assign n_eff     = (n_raw == '0) ? CNT_W'(1) : n_raw;
	assign close_grp = (cnt_n >= n_eff);

	assign w_eff = (wgt_q == '0) ? 9'd1 : ((wgt_q > 9'd256) ? 9'd256 : wgt_q);
	assign w_inv = 9'd256 - w_eff;
	assign fs10  = FS10_W'({fs_q, 3'b000}) + FS10_W'({fs_q, 1'b0});

	assign mul_p = mul_a * mul_b;

	// restoring divider step
	assign trial  = {drem_q, dnum_q[DIV_W-1]};
	assign div_ge = (trial >= {1'b0, dden_q});
	assign rem_n  = div_ge ? DEN_W'(trial - {1'b0, dden_q}) : trial[DEN_W-1:0];

	assign lvl_ge    = (sm_q >= zero_q);
	assign abs_diff  = lvl_ge ? (sm_q - zero_q) : (zero_q - sm_q);
	assign band      = (abs_diff < LVL_W'(db_q));
	assign zero_span = (LVL_W'(TOP_LEVEL) <= zero_q);
	assign den       = TOP_LEVEL - zero_q[DEN_W-1:0];

	assign load_out = (state_q == ST_OUT) && (!result_valid_q || result_ready);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:       if (sample_valid && close_grp) state_n = ST_DIV_MEAN;
			ST_DIV_MEAN:   if (dcnt_q == '0) state_n = ST_MEAN_DONE;
			ST_MEAN_DONE:  state_n = kind_q ? ST_OUT : ST_EMA_A;
			ST_EMA_A:      state_n = ST_EMA_B;
			ST_EMA_B:      state_n = ST_EMA_C;
			ST_EMA_C:      state_n = ST_CMP;
			ST_CMP:        state_n = (!band && lvl_ge && !zero_span) ? ST_MUL : ST_OUT;
			ST_MUL:        state_n = ST_DIV_LOAD;
			ST_DIV_LOAD:   state_n = ST_DIV_PRESS;
			ST_DIV_PRESS:  if (dcnt_q == '0) state_n = ST_PRESS_DONE;
			ST_PRESS_DONE: state_n = ST_OUT;
			ST_OUT:        if (load_out) state_n = ST_IDLE;
			default:       state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		mul_a        = sm_q;
		mul_b        = FS10_W'(w_inv);
		unique case (state_q)
			ST_IDLE:  sample_ready = 1'b1;
			ST_EMA_A: begin
				mul_a = mean_q;
				mul_b = FS10_W'(w_eff);
			end
			ST_MUL: begin
				mul_a = diff_q;
				mul_b = fs10;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= 7'd20;
			cal_q <= 8'd200;
			wgt_q <= 9'd51;
			db_q  <= 16'd1571;
			fs_q  <= 10'd500;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SAMPLES_PER_READING: spr_q <= cfg_wdata[6:0];
				REG_CALIBRATION_SAMPLES: cal_q <= cfg_wdata[7:0];
				REG_SMOOTHING_WEIGHT:    wgt_q <= cfg_wdata[8:0];
				REG_DEADBAND_LEVEL:      db_q  <= cfg_wdata[15:0];
				REG_FULL_SCALE_KPA:      fs_q  <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sum_q          <= '0;
			cnt_q          <= '0;
			grp_q          <= 1'b0;
			sm_q           <= '0;
			zero_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (result_valid_q && result_ready) result_valid_q <= 1'b0;
			if (load_out) result_valid_q <= 1'b1;
			if (state_q == ST_IDLE && sample_valid) begin
				grp_q <= sample.req_type;
				if (close_grp) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
				end
			end
			if (state_q == ST_MEAN_DONE && kind_q) begin
				zero_q <= dnum_q[LVL_W-1:0];
				sm_q   <= dnum_q[LVL_W-1:0];
			end
			if (state_q == ST_EMA_C) sm_q <= acc_q[LVL_W+7:8];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q <= sample.req_type;
				dnum_q <= DIV_W'({sum_n, 8'h00} + LVL_W'(n_eff >> 1));
				drem_q <= '0;
				dden_q <= DEN_W'(n_eff);
				dcnt_q <= DCNT_W'(DIV_W - 1);
			end
			ST_DIV_MEAN, ST_DIV_PRESS: begin
				dnum_q <= {dnum_q[DIV_W-2:0], div_ge};
				drem_q <= rem_n;
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_MEAN_DONE: begin
				mean_q <= dnum_q[LVL_W-1:0];
				res_q  <= '{result_kind: 1'b1, pressure_tenths_kpa: '0, in_deadband: 1'b0,
					zero_level: dnum_q[17:0]};
			end
			ST_EMA_A: acc_q <= mul_p;
			ST_EMA_B: acc_q <= acc_q + mul_p + DIV_W'(128);
			ST_CMP: begin
				diff_q <= abs_diff;
				res_q  <= '{result_kind: 1'b0,
					pressure_tenths_kpa: (!band && lvl_ge && zero_span) ? fs10 : '0,
					in_deadband: band, zero_level: zero_q[17:0]};
			end
			ST_MUL: acc_q <= mul_p;
			ST_DIV_LOAD: begin
				dnum_q <= acc_q + DIV_W'(den >> 1);
				drem_q <= '0;
				dden_q <= den;
				dcnt_q <= DCNT_W'(DIV_W - 1);
			end
			ST_PRESS_DONE: res_q.pressure_tenths_kpa <=
				(dnum_q > DIV_W'(fs10)) ? fs10 : dnum_q[FS10_W-1:0];
			ST_OUT: if (load_out) result_q <= res_q;
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: design/psc_checker.sv
// Port-level checker for pressure_sensor_conditioner_core, bound into the core module.
// Uses psc_pkg for the result item type and the full-scale limit.
`timescale 1ns / 1ps

module psc_checker
	import psc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped before the item was taken");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result item changed while stalled");

	a_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.in_deadband |-> result.pressure_tenths_kpa == '0)
		else $error("nonzero pressure inside deadband");

	a_cal_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind |->
			result.pressure_tenths_kpa == '0 && !result.in_deadband)
		else $error("calibration item carries pressure or deadband flag");

	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.pressure_tenths_kpa <= FS10_MAX)
		else $error("pressure above largest full scale");

endmodule

bind pressure_sensor_conditioner_core psc_checker u_psc_checker (.*);
